### hw/rtl/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and codes of the parcel ring queue: field widths, action and
// status codes, stored record layout and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int ACTION_W   = 2;
  localparam int ID_W       = 32;
  localparam int WEIGHT_W   = 24;
  localparam int DEST_W     = 16;
  localparam int PRIO_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 7;

  localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_INSPECT = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_REPORT  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [WEIGHT_W-1:0] weight;
    logic [DEST_W-1:0]   dest;
    logic [PRIO_W-1:0]   prio;
  } record_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic exec;
    logic scan;
    logic div_start;
    logic div_step;
    logic load_out;
  } prq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                empty;
    logic                scan_done;
    logic                no_match;
    logic                div_last;
  } prq_sts_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_id;
    logic [WEIGHT_W-1:0] out_weight;
    logic [DEST_W-1:0]   out_destination;
    logic [PRIO_W-1:0]   out_priority;
    logic                out_dispatched;
    logic [OCC_W-1:0]    occupancy;
    logic [OCC_W-1:0]    match_count;
    logic [WEIGHT_W-1:0] mean_weight;
  } result_t;

endpackage

### hw/rtl/prq_in_if.sv
// ----------------------------------------------------------------------------
// prq_in_if
// Request channel of the parcel ring queue: valid/ready plus request fields.
// ----------------------------------------------------------------------------
interface prq_in_if;
  logic                          valid;
  logic                          ready;
  logic [prq_pkg::ACTION_W-1:0]  action;
  logic signed [prq_pkg::ID_W-1:0] package_id;
  logic [prq_pkg::WEIGHT_W-1:0]  weight_q8;
  logic [prq_pkg::DEST_W-1:0]    destination_code;
  logic [prq_pkg::PRIO_W-1:0]    priority_level;

  modport source (output valid, action, package_id, weight_q8, destination_code,
                  priority_level, input ready);
  modport sink   (input valid, action, package_id, weight_q8, destination_code,
                  priority_level, output ready);
endinterface

### hw/rtl/prq_out_if.sv
// ----------------------------------------------------------------------------
// prq_out_if
// Result channel of the parcel ring queue: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface prq_out_if;
  logic                            valid;
  logic                            ready;
  logic [prq_pkg::STATUS_W-1:0]    status;
  logic signed [prq_pkg::ID_W-1:0] out_id;
  logic [prq_pkg::WEIGHT_W-1:0]    out_weight;
  logic [prq_pkg::DEST_W-1:0]      out_destination;
  logic [prq_pkg::PRIO_W-1:0]      out_priority;
  logic                            out_dispatched;
  logic [prq_pkg::OCC_W-1:0]       occupancy;
  logic [prq_pkg::OCC_W-1:0]       match_count;
  logic [prq_pkg::WEIGHT_W-1:0]    mean_weight;

  modport source (output valid, status, out_id, out_weight, out_destination,
                  out_priority, out_dispatched, occupancy, match_count,
                  mean_weight, input ready);
  modport sink   (input valid, status, out_id, out_weight, out_destination,
                  out_priority, out_dispatched, occupancy, match_count,
                  mean_weight, output ready);
endinterface

### hw/rtl/prq_ctrl.sv
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer of the parcel ring queue: accepts a request, runs the execute phase
// and, for a report, scan and divide phases in the datapath and hands the result to the output stage.
// ----------------------------------------------------------------------------
module prq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  prq_pkg::prq_sts_t sts,
  output prq_pkg::prq_cmd_t cmd
);
  import prq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SCAN = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.action == ACT_REPORT && !sts.empty) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          if (sts.no_match) begin
            state_nxt = S_DONE;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/prq_dpath.sv
// ----------------------------------------------------------------------------
// prq_dpath
// Datapath of the parcel ring queue: record memory, head/tail/count pointers,
// occupied-range scan with match accumulator, serial divider, result register.
// ----------------------------------------------------------------------------
module prq_dpath #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [prq_pkg::ACTION_W-1:0]   in_action,
  input  logic [prq_pkg::ID_W-1:0]       in_id,
  input  logic [prq_pkg::WEIGHT_W-1:0]   in_weight,
  input  logic [prq_pkg::DEST_W-1:0]     in_dest,
  input  logic [prq_pkg::PRIO_W-1:0]     in_prio,
  input  prq_pkg::prq_cmd_t              cmd,
  output prq_pkg::prq_sts_t              sts,
  output prq_pkg::result_t               res
);
  import prq_pkg::*;

  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = WEIGHT_W + AW;
  localparam int DSW = $clog2(SW);
  localparam logic [AW-1:0]  LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0]  DEPTH_C   = CW'(QUEUE_DEPTH);
  localparam logic [DSW-1:0] LAST_STEP = DSW'(SW - 1);

  record_t mem [QUEUE_DEPTH];

  // latched request
  logic [ACTION_W-1:0] act_r;
  record_t             req_r;

  // queue pointers and scan control
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] sp_r;
  logic [CW-1:0] issued_r;
  logic          rd_vld_r, rd_vld_nxt;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  record_t       rd_data_r;

  // accumulator, divider, staged status
  logic [SW-1:0]       sum_r;
  logic [CW-1:0]       mcnt_r;
  logic [CW-1:0]       rem_r;
  logic [SW-1:0]       quo_r;
  logic [DSW-1:0]      dstep_r;
  logic [STATUS_W-1:0] st_r;
  result_t             res_r;

  logic          empty, full, is_rec, scan_more;
  logic [CW:0]   trial, diff;
  logic          ge;
  logic [STATUS_W-1:0] fin_status;
  logic          rec_ok, rep_ok;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign empty     = (count_r == '0);
  assign full      = (count_r == DEPTH_C);
  assign is_rec    = (act_r == ACT_DEQUEUE) || (act_r == ACT_INSPECT);
  assign scan_more = (issued_r != count_r);

  // read port: head record on execute, occupied slots in order while scanning
  assign rd_en   = (cmd.exec && is_rec && !empty) || (cmd.scan && scan_more);
  assign rd_addr = cmd.scan ? sp_r : head_r;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    rd_vld_nxt = cmd.scan && scan_more;
    if (cmd.exec) begin
      if (act_r == ACT_ENQUEUE && !full) begin
        tail_nxt  = next_slot(tail_r);
        count_nxt = count_r + 1'b1;
      end else if (act_r == ACT_DEQUEUE && !empty) begin
        head_nxt  = next_slot(head_r);
        count_nxt = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // record memory
  always_ff @(posedge clk) begin
    if (cmd.exec && act_r == ACT_ENQUEUE && !full) begin
      mem[tail_r] <= req_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_r       <= in_action;
      req_r.id     <= in_id;
      req_r.weight <= in_weight;
      req_r.dest   <= in_dest;
      req_r.prio   <= in_prio;
    end
  end

  // restoring divider step: one quotient bit per cycle
  assign trial = {rem_r, quo_r[SW-1]};
  assign diff  = trial - {1'b0, mcnt_r};
  assign ge    = (trial >= {1'b0, mcnt_r});

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st_r     <= (act_r == ACT_ENQUEUE) ? (full ? ST_FULL : ST_OK)
                                         : (empty ? ST_EMPTY : ST_OK);
      sp_r     <= head_r;
      issued_r <= '0;
      sum_r    <= '0;
      mcnt_r   <= '0;
    end
    if (cmd.scan) begin
      if (scan_more) begin
        sp_r     <= next_slot(sp_r);
        issued_r <= issued_r + 1'b1;
      end
      if (rd_vld_r && rd_data_r.dest == req_r.dest) begin
        sum_r  <= sum_r + SW'(rd_data_r.weight);
        mcnt_r <= mcnt_r + 1'b1;
      end
    end
    if (cmd.div_start) begin
      rem_r   <= '0;
      quo_r   <= sum_r;
      dstep_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r   <= ge ? diff[CW-1:0] : trial[CW-1:0];
      quo_r   <= {quo_r[SW-2:0], ge};
      dstep_r <= dstep_r + 1'b1;
    end
  end

  // result assembly
  always_comb begin
    fin_status = st_r;
    if (act_r == ACT_REPORT && st_r == ST_OK && mcnt_r == '0) begin
      fin_status = ST_NOMATCH;
    end
  end

  assign rec_ok = (st_r == ST_OK) && is_rec;
  assign rep_ok = (fin_status == ST_OK) && (act_r == ACT_REPORT);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_r.status          <= fin_status;
      res_r.out_id          <= rec_ok ? rd_data_r.id : '0;
      res_r.out_weight      <= rec_ok ? rd_data_r.weight : '0;
      res_r.out_destination <= rec_ok ? rd_data_r.dest : '0;
      res_r.out_priority    <= rec_ok ? rd_data_r.prio : '0;
      res_r.out_dispatched  <= rec_ok && (act_r == ACT_DEQUEUE);
      res_r.occupancy       <= OCC_W'(count_r);
      res_r.match_count     <= rep_ok ? OCC_W'(mcnt_r) : '0;
      res_r.mean_weight     <= rep_ok ? quo_r[WEIGHT_W-1:0] : '0;
    end
  end

  assign res           = res_r;
  assign sts.action    = act_r;
  assign sts.empty     = empty;
  assign sts.scan_done = !scan_more && !rd_vld_r;
  assign sts.no_match  = (mcnt_r == '0);
  assign sts.div_last  = (dstep_r == LAST_STEP);

endmodule

### hw/rtl/parcel_ring_queue_with_report.sv
// ----------------------------------------------------------------------------
// parcel_ring_queue_with_report
// Circular queue of parcel records with enqueue, dequeue, inspect and a
// destination report giving match count and truncated mean weight.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request transaction (action, id, weight, destination,
//   priority); out_ch returns one result transaction per request, in order.
//   Enqueue, dequeue and inspect run the execute and done states before the
//   result is registered; requests are accepted only in the idle state, one
//   at a time. A report walks the occupied slots from the head through the
//   single registered read port of the record memory, then a restoring
//   divider produces one quotient bit per cycle for the mean weight; without
//   a match the divider is skipped, and on an empty queue the scan as well.
//   A finished result sits in the output register; the next request is
//   accepted and executed meanwhile and only its hand-off waits for out_ready.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result. Record memory is not cleared; only occupied slots are ever read.
// ----------------------------------------------------------------------------
module parcel_ring_queue_with_report #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  prq_in_if.sink    in_ch,
  prq_out_if.source out_ch
);
  import prq_pkg::*;

  prq_cmd_t cmd;
  prq_sts_t sts;
  result_t  res;

  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_action (in_ch.action),
    .in_id     (in_ch.package_id),
    .in_weight (in_ch.weight_q8),
    .in_dest   (in_ch.destination_code),
    .in_prio   (in_ch.priority_level),
    .cmd       (cmd),
    .sts       (sts),
    .res       (res)
  );

  assign out_ch.status          = res.status;
  assign out_ch.out_id          = res.out_id;
  assign out_ch.out_weight      = res.out_weight;
  assign out_ch.out_destination = res.out_destination;
  assign out_ch.out_priority    = res.out_priority;
  assign out_ch.out_dispatched  = res.out_dispatched;
  assign out_ch.occupancy       = res.occupancy;
  assign out_ch.match_count     = res.match_count;
  assign out_ch.mean_weight     = res.mean_weight;

endmodule

### tb/prq_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prq_result_checker
// Watches the request and result channels of the parcel ring queue. It keeps
// its own copy of the queue state, works out the result of each accepted
// request, and compares every result transaction field by field in order.
// ----------------------------------------------------------------------------
module prq_result_checker #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  prq_in_if    in_mon,
  prq_out_if   out_mon,
  output int   fail_count,
  output int   pending_count
);
  import prq_pkg::*;

  logic [ID_W-1:0]     id_mem     [QUEUE_DEPTH];
  logic [WEIGHT_W-1:0] weight_mem [QUEUE_DEPTH];
  logic [DEST_W-1:0]   dest_mem   [QUEUE_DEPTH];
  logic [PRIO_W-1:0]   prio_mem   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] queued;
  int head_slot;
  int tail_slot;
  int entries;

  result_t expected_results[$];
  result_t want;
  int errors = 0;
  int pending = 0;

  assign fail_count    = errors;
  assign pending_count = pending;

  function automatic int next_slot(input int slot);
    return (slot + 1 >= QUEUE_DEPTH) ? 0 : slot + 1;
  endfunction

  // Applies one request to the local queue copy and returns its result.
  function automatic result_t predict_parcel_result(
    input logic [ACTION_W-1:0] act,
    input logic [ID_W-1:0]     pid,
    input logic [WEIGHT_W-1:0] wgt,
    input logic [DEST_W-1:0]   dest,
    input logic [PRIO_W-1:0]   prio
  );
    result_t         r;
    int              hits;
    longint unsigned wsum;
    r    = '0;
    hits = 0;
    wsum = 0;
    r.status = ST_OK;
    if (act == ACT_ENQUEUE) begin
      if (entries >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        id_mem[tail_slot]     = pid;
        weight_mem[tail_slot] = wgt;
        dest_mem[tail_slot]   = dest;
        prio_mem[tail_slot]   = prio;
        queued[tail_slot]     = 1'b1;
        tail_slot = next_slot(tail_slot);
        entries++;
      end
    end else if (entries == 0) begin
      r.status = ST_EMPTY;
    end else if (act == ACT_DEQUEUE || act == ACT_INSPECT) begin
      r.out_id          = id_mem[head_slot];
      r.out_weight      = weight_mem[head_slot];
      r.out_destination = dest_mem[head_slot];
      r.out_priority    = prio_mem[head_slot];
      if (act == ACT_DEQUEUE) begin
        queued[head_slot] = 1'b0;
        r.out_dispatched  = 1'b1;
        head_slot = next_slot(head_slot);
        entries--;
      end else begin
        r.out_dispatched = !queued[head_slot];
      end
    end else begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (queued[i] && dest_mem[i] == dest) begin
          hits++;
          wsum += weight_mem[i];
        end
      end
      if (hits == 0) begin
        r.status = ST_NOMATCH;
      end else begin
        r.match_count = OCC_W'(hits);
        r.mean_weight = WEIGHT_W'(wsum / longint'(hits));
      end
    end
    r.occupancy = OCC_W'(entries);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      queued    = '0;
      head_slot = 0;
      tail_slot = 0;
      entries   = 0;
      expected_results.delete();
      pending = 0;
    end else begin
      // a result completing at this edge always belongs to an older request
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected, status 0x%0h",
                 out_mon.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status",          want.status,          out_mon.status);
          check_field("out_id",          want.out_id,          out_mon.out_id);
          check_field("out_weight",      want.out_weight,      out_mon.out_weight);
          check_field("out_destination", want.out_destination, out_mon.out_destination);
          check_field("out_priority",    want.out_priority,    out_mon.out_priority);
          check_field("out_dispatched",  want.out_dispatched,  out_mon.out_dispatched);
          check_field("occupancy",       want.occupancy,       out_mon.occupancy);
          check_field("match_count",     want.match_count,     out_mon.match_count);
          check_field("mean_weight",     want.mean_weight,     out_mon.mean_weight);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_results.push_back(predict_parcel_result(in_mon.action,
          in_mon.package_id, in_mon.weight_q8, in_mon.destination_code,
          in_mon.priority_level));
      end
      pending = expected_results.size();
    end
  end

endmodule

### tb/tb_parcel_ring_queue_with_report.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_parcel_ring_queue_with_report
// Drives directed and random queue requests (enqueue, dequeue, inspect and
// destination report) with random gaps and result back-pressure; the checker
// instance predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_parcel_ring_queue_with_report;
  import prq_pkg::*;

  localparam int QUEUE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASE_LEN    = 140;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} load_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   calm  = 1'b0;  // no gaps or stalls on either side while set
  int   fail_count;
  int   pending_count;

  logic [DEST_W-1:0] dest_pool [4] = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'h8001};

  prq_in_if  in_ch ();
  prq_out_if out_ch ();

  parcel_ring_queue_with_report #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  prq_result_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("tb_parcel_ring_queue_with_report: FAIL");
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 23);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] pid,
                              input logic [WEIGHT_W-1:0] wgt, input logic [DEST_W-1:0] dest,
                              input logic [PRIO_W-1:0] prio);
    while (!calm && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.action           <= act;
    in_ch.package_id       <= pid;
    in_ch.weight_q8        <= wgt;
    in_ch.destination_code <= dest;
    in_ch.priority_level   <= prio;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic [DEST_W-1:0] pick_destination();
    if ($urandom_range(9) < 8) return dest_pool[$urandom_range(3)];
    return DEST_W'($urandom());
  endfunction

  task automatic random_request(input load_mode_t mode);
    int                  roll;
    logic [ACTION_W-1:0] act;
    logic [WEIGHT_W-1:0] wgt;
    logic [PRIO_W-1:0]   prio;
    roll = $urandom_range(99);
    case (mode)
      MODE_FILL:  act = (roll < 70) ? ACT_ENQUEUE : (roll < 80) ? ACT_DEQUEUE :
                        (roll < 90) ? ACT_INSPECT : ACT_REPORT;
      MODE_DRAIN: act = (roll < 15) ? ACT_ENQUEUE : (roll < 80) ? ACT_DEQUEUE :
                        (roll < 90) ? ACT_INSPECT : ACT_REPORT;
      default:    act = (roll < 40) ? ACT_ENQUEUE : (roll < 75) ? ACT_DEQUEUE :
                        (roll < 87) ? ACT_INSPECT : ACT_REPORT;
    endcase
    roll = $urandom_range(7);
    wgt  = (roll == 0) ? '1 : (roll == 1) ? '0 : WEIGHT_W'($urandom());
    prio = ($urandom_range(19) == 0) ? 2'd0 : PRIO_W'($urandom_range(3, 1));
    send_request(act, $urandom(), wgt, pick_destination(), prio);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    wait (pending_count == 0);
    @(negedge clk);
  endtask

  initial begin
    in_ch.valid            = 1'b0;
    in_ch.action           = ACT_INSPECT;
    in_ch.package_id       = '0;
    in_ch.weight_q8        = '0;
    in_ch.destination_code = '0;
    in_ch.priority_level   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue
    send_request(ACT_REPORT,  '0, '0, 16'h0000, 2'd1);
    send_request(ACT_DEQUEUE, '0, '0, 16'h0000, 2'd1);
    send_request(ACT_INSPECT, '0, '0, 16'h0000, 2'd1);
    // field extremes
    send_request(ACT_ENQUEUE, 32'h8000_0000, 24'hFF_FFFF, 16'hFFFF, 2'd3);
    send_request(ACT_ENQUEUE, 32'h7FFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 2'd1);
    send_request(ACT_ENQUEUE, 32'h0000_0000, 24'h00_0000, 16'h0000, 2'd0);
    send_request(ACT_ENQUEUE, 32'hFFFF_FFFF, 24'h00_0001, 16'hFFFF, 2'd2);
    send_request(ACT_INSPECT, '0, '0, 16'h0000, 2'd1);
    // truncating mean, zero-weight match, no match
    send_request(ACT_REPORT,  '0, '0, 16'hFFFF, 2'd1);
    send_request(ACT_REPORT,  '0, '0, 16'h0000, 2'd1);
    send_request(ACT_REPORT,  '0, '0, 16'h1234, 2'd1);
    send_request(ACT_DEQUEUE, '0, '0, 16'h0000, 2'd1);
    send_request(ACT_INSPECT, '0, '0, 16'h0000, 2'd1);
    send_request(ACT_REPORT,  '0, '0, 16'hFFFF, 2'd1);
    // drain past empty
    repeat (4) send_request(ACT_DEQUEUE, '0, '0, 16'h0000, 2'd1);
    send_request(ACT_INSPECT, '0, '0, 16'h0000, 2'd1);
    send_request(ACT_ENQUEUE, 32'h1234_5678, 24'h80_0000, 16'h8000, 2'd3);
    send_request(ACT_REPORT,  '0, '0, 16'h8000, 2'd1);
    hold_until_drained();

    // phases alternate fill, drain and mixed load so full and empty both recur
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 600 && n < 850);
      if (n == 1000) hold_until_drained();
      random_request(load_mode_t'((n / PHASE_LEN) % 3));
    end
    in_ch.valid <= 1'b0;

    wait (pending_count == 0);
    repeat (150) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_parcel_ring_queue_with_report: PASS");
    end else begin
      $display("tb_parcel_ring_queue_with_report: FAIL");
    end
    $finish;
  end

endmodule
